### rtl/dngr_pkg.sv
// ----------------------------------------------------------------------------
// dngr_pkg: shared types and constants for the decimal glyph renderer
// Transaction structs, controller/datapath interface and the 6x8 digit font.
// ----------------------------------------------------------------------------
package dngr_pkg;

    localparam int VALUE_W     = 32;
    localparam int COL_W       = 7;
    localparam int PAGE_W      = 3;
    localparam int GLYPH_W     = 48;
    localparam int DEC_DIGITS  = 10;                     // digits of a 32-bit value
    localparam int DIGIT_IDX_W = $clog2(DEC_DIGITS);
    localparam int ITER_W      = $clog2(VALUE_W);
    localparam int RIGHT_LIMIT = 126;
    localparam int GLYPH_COLS  = 6;

    typedef struct packed {
        logic [COL_W-1:0]   start_column;
        logic [PAGE_W-1:0]  page;
        logic [VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [PAGE_W-1:0]  out_page;
        logic [COL_W-1:0]   out_column;
        logic [GLYPH_W-1:0] glyph;
        logic               last_digit;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIZE,
        ST_EMIT
    } t_state;

    // Controller -> datapath
    typedef struct packed {
        logic load;     // capture input transaction
        logic step;     // one shift-and-add-3 iteration
        logic size;     // digit count and column clamp
        logic adv;      // result taken, move to next digit
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic last;     // current digit is the final one
    } t_dp_stat;

    // Font columns, byte 0 in the low bits
    function automatic logic [GLYPH_W-1:0] font_glyph(input logic [3:0] d);
        logic [GLYPH_W-1:0] g;
        unique case (d)
            4'd1:    g = 48'h0040_7F42_0000;
            4'd2:    g = 48'h4649_5161_4200;
            4'd3:    g = 48'h314B_4541_2100;
            4'd4:    g = 48'h107F_1214_1800;
            4'd5:    g = 48'h3945_4545_2700;
            4'd6:    g = 48'h3049_494A_3C00;
            4'd7:    g = 48'h0305_0971_0100;
            4'd8:    g = 48'h3649_4949_3600;
            4'd9:    g = 48'h1E29_4949_0600;
            default: g = 48'h3E45_4951_3E00;   // zero, and non-decimal codes
        endcase
        return g;
    endfunction

endpackage

### rtl/dngr_datapath.sv
// ----------------------------------------------------------------------------
// dngr_datapath: conversion and emission datapath
// Serial binary-to-BCD (shift and add 3), digit count, column clamp, glyphs.
// ----------------------------------------------------------------------------
module dngr_datapath #(
    parameter int MAX_DIGITS = 10
) (
    input  logic                i_clk,
    input  dngr_pkg::t_in_item  i_in,
    input  dngr_pkg::t_dp_cmd   i_cmd,
    output dngr_pkg::t_dp_stat  o_stat,
    output dngr_pkg::t_out_item o_out
);
    import dngr_pkg::*;

    localparam int ND = (MAX_DIGITS > DEC_DIGITS) ? DEC_DIGITS : MAX_DIGITS;
    localparam logic [COL_W:0] LIMIT = (COL_W+1)'(RIGHT_LIMIT);

    logic [DEC_DIGITS-1:0][3:0]  r_bcd, n_bcd, adj;
    logic [DEC_DIGITS*4-1:0]     adj_flat;
    logic [VALUE_W-1:0]          r_bin, n_bin;
    logic [COL_W-1:0]            r_col, n_col;
    logic [PAGE_W-1:0]           r_page;
    logic [DIGIT_IDX_W-1:0]      r_pos, n_pos;
    logic [DIGIT_IDX_W-1:0]      top, cnt_raw, cnt;
    logic [COL_W:0]              span, reach;

    // add 3 to each digit of 5 or more before the shift
    always_comb begin
        for (int k = 0; k < DEC_DIGITS; k++) begin
            adj[k] = (r_bcd[k] >= 4'd5) ? r_bcd[k] + 4'd3 : r_bcd[k];
        end
        adj_flat = adj;
    end

    // most significant nonzero digit; zero still counts one digit
    always_comb begin
        top = '0;
        for (int k = 0; k < DEC_DIGITS; k++) begin
            if (r_bcd[k] != 4'd0) top = DIGIT_IDX_W'(k);
        end
        cnt_raw = top + 1'b1;
        cnt     = (cnt_raw > DIGIT_IDX_W'(ND)) ? DIGIT_IDX_W'(ND) : cnt_raw;
        span    = (COL_W+1)'(cnt) * (COL_W+1)'(GLYPH_COLS);
        reach   = {1'b0, r_col} + span;
    end

    always_comb begin
        n_bcd = r_bcd;
        n_bin = r_bin;
        n_col = r_col;
        n_pos = r_pos;
        if (i_cmd.load) begin
            n_bcd = '0;
            n_bin = i_in.value;
            n_col = i_in.start_column;
        end else if (i_cmd.step) begin
            n_bcd = {adj_flat[DEC_DIGITS*4-2:0], r_bin[VALUE_W-1]};
            n_bin = {r_bin[VALUE_W-2:0], 1'b0};
        end else if (i_cmd.size) begin
            n_pos = cnt - 1'b1;
            if (reach > LIMIT) begin
                n_col = COL_W'(LIMIT - span);
            end
        end else if (i_cmd.adv) begin
            n_pos = r_pos - 1'b1;
            n_col = r_col + COL_W'(GLYPH_COLS);
        end
    end

    always_ff @(posedge i_clk) begin
        r_bcd <= n_bcd;
        r_bin <= n_bin;
        r_col <= n_col;
        r_pos <= n_pos;
        if (i_cmd.load) r_page <= i_in.page;
    end

    assign o_stat.last      = (r_pos == '0);
    assign o_out.out_page   = r_page;
    assign o_out.out_column = r_col;
    assign o_out.glyph      = font_glyph(r_bcd[r_pos]);
    assign o_out.last_digit = (r_pos == '0);

`ifndef NO_ASSERTIONS
    // stepping to the next digit moves the column one glyph right
    a_col_step: assert property (@(posedge i_clk)
        i_cmd.adv && !o_stat.last |=> r_col == $past(r_col) + COL_W'(GLYPH_COLS))
        else $error("column did not advance by one glyph");

    // clamped first digit row always ends inside the limit
    a_clamp: assert property (@(posedge i_clk)
        i_cmd.size |=> ({1'b0, r_col} + (COL_W+1)'(r_pos + 1'b1) * (COL_W+1)'(GLYPH_COLS))
                       <= LIMIT)
        else $error("digits run past the right limit");
`endif

endmodule

### rtl/dngr_ctrl.sv
// ----------------------------------------------------------------------------
// dngr_ctrl: transaction sequencer
// Accepts a transaction, runs the conversion iterations, then hands out digits.
// ----------------------------------------------------------------------------
module dngr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    input  dngr_pkg::t_dp_stat i_stat,
    output dngr_pkg::t_dp_cmd  o_cmd
);
    import dngr_pkg::*;

    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(VALUE_W - 1);

    t_state              r_state, n_state;
    logic [ITER_W-1:0]   r_iter, n_iter;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_CONV;
            ST_CONV: if (r_iter == ITER_LAST) n_state = ST_SIZE;
            ST_SIZE: n_state = ST_EMIT;
            ST_EMIT: if (!i_out_stall && i_stat.last) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        n_iter      = r_iter;
        unique case (r_state)
            ST_IDLE: begin
                // input held off while reset is asserted
                o_in_stall = !i_rst_n;
                o_cmd.load = i_in_valid && i_rst_n;
                n_iter     = '0;
            end
            ST_CONV: begin
                o_cmd.step = 1'b1;
                n_iter     = r_iter + 1'b1;
            end
            ST_SIZE: o_cmd.size = 1'b1;
            ST_EMIT: begin
                o_out_valid = 1'b1;
                o_cmd.adv   = !i_out_stall;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
        end
    end

`ifndef NO_ASSERTIONS
    // one transaction in flight: no input taken while a result is offered
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open while results pending");

    // final digit taken ends the result stream
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && i_stat.last |=> !o_out_valid && !o_in_stall)
        else $error("results continued past final digit");

    // conversion takes exactly one iteration per value bit
    a_conv_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_CONV && r_iter == ITER_LAST |=> r_state == ST_SIZE)
        else $error("conversion length wrong");
`endif

endmodule

### rtl/decimal_number_glyph_renderer.sv
// After an input transaction is accepted, the sequencer converts the value, sizes the
// digit row and then offers one result per digit shown (1..10).
// The conversion is the bit-serial shift-and-add-3 converter, one value bit a cycle.
// One transaction at a time; input stalls until the final digit is taken.
// Reset (synchronous, active low) returns the sequencer to idle; no clearing pass.
// ----------------------------------------------------------------------------
// decimal_number_glyph_renderer: unsigned value to 6x8 digit glyphs
// Converts a 32-bit value to decimal and emits one font glyph per digit,
// most significant first, with columns clamped to the right screen edge.
// ----------------------------------------------------------------------------
module decimal_number_glyph_renderer #(
    parameter int MAX_DIGITS = 10     // 1..20; at most ten digits exist
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input transaction channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  dngr_pkg::t_in_item  i_in,
    // result transaction channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output dngr_pkg::t_out_item o_out
);
    import dngr_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequencer: idle -> convert (one iteration per value bit) -> size -> emit digits.
    // The result payload comes straight from datapath registers, which only
    // change when a result transaction completes, so a stalled result holds.
    dngr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Datapath: ten BCD digits are always built so the digit count is exact;
    // only the MAX_DIGITS least significant ones are shown, and the clamp uses
    // that shown count.
    dngr_datapath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .i_clk  (i_clk),
        .i_in   (i_in),
        .i_cmd  (cmd),
        .o_stat (stat),
        .o_out  (o_out)
    );

endmodule
